@@ hdl/llcdt_pkg.sv @@
// Shared types and constants for the LLC conversation direction tracker.
// No dependencies.
package llcdt_pkg;

    localparam int MAC_W = 48;
    localparam int SAP_W = 8;
    localparam int CTL_W = 8;

    // Control byte classification
    localparam logic [CTL_W-1:0] AC_MASK  = 8'h6f;
    localparam logic [CTL_W-1:0] AC_VALUE = 8'h67;
    localparam logic [CTL_W-1:0] UNNUM    = 8'h00;
    localparam int PF_POS  = 4;
    localparam int SEQ_POS = 7;

    // Conversation key: both MACs and both SAPs
    typedef struct packed {
        logic [MAC_W-1:0] dmac;
        logic [MAC_W-1:0] smac;
        logic [SAP_W-1:0] dsap;
        logic [SAP_W-1:0] ssap;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    // One table entry: key plus command flag
    typedef struct packed {
        t_key key;
        logic flag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Compare result from the key comparator
    typedef struct packed {
        logic fwd_hit;
        logic rev_hit;
    } t_match;

endpackage

@@ hdl/llcdt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module llcdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/llcdt_key_cmp.sv @@
// Key comparator: checks a stored key against the frame key in both directions.
// Depends on llcdt_pkg.
module llcdt_key_cmp
    import llcdt_pkg::*;
(
    input  t_key   i_stored,
    input  t_key   i_frame,
    output t_match o_match
);

    t_key w_rev;

    // Frame key with MACs and SAPs swapped
    always_comb begin
        w_rev.dmac = i_frame.smac;
        w_rev.smac = i_frame.dmac;
        w_rev.dsap = i_frame.ssap;
        w_rev.ssap = i_frame.dsap;
    end

    assign o_match.fwd_hit = (i_stored == i_frame);
    assign o_match.rev_hit = (i_stored == w_rev);

endmodule

@@ hdl/llc_conversation_direction_tracker_unit.sv @@
// LLC conversation direction tracker, top level.
// Depends on llcdt_pkg, llcdt_ram and llcdt_key_cmp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one frame's addressing:
//   both MACs, both SAPs and the LLC control byte. Output channel
//   (o_out_valid / i_out_ready) returns one result per frame: the control
//   byte class bits, command/response and the table-full flag.
//   The block handles one frame at a time; o_in_ready is high only while the
//   sequencer is idle. An AC frame scans the conversation table one entry
//   at a time (RAM read, then compare) through a single key comparator.
//   A non-AC frame skips the table; a hit ends the scan at the matching
//   entry, and a miss scans every stored entry before the insert step.
//   A finished result sits in the output register; the next frame may be
//   taken while it waits, but a second result waits in the sequencer until
//   the output register is free, so a stalled receiver stalls the input.
//   Reset empties the table (entry count to zero) and drops any pending
//   result; no clearing pass is needed.
module llc_conversation_direction_tracker_unit
    import llcdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [MAC_W-1:0] i_dest_mac,
    input  logic [MAC_W-1:0] i_source_mac,
    input  logic [SAP_W-1:0] i_dest_sap,
    input  logic [SAP_W-1:0] i_source_sap,
    input  logic [CTL_W-1:0] i_llc_control,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_is_ack_connless,
    output logic             o_ac_sequence,
    output logic             o_poll_final,
    output logic             o_is_unnumbered,
    output logic             o_is_command,
    output logic             o_table_full
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    t_key             r_key;
    logic             r_is_ac, r_seq, r_pf, r_unnum;
    logic             r_cmd, n_cmd;
    logic             r_full, n_full;

    logic             r_out_valid, n_out_valid;
    logic             r_out_ac, r_out_seq, r_out_pf, r_out_unnum, r_out_cmd, r_out_full;

    logic             w_in_xfer;
    logic             w_out_free;
    logic             w_last;
    logic             w_ac;
    logic [CTL_W-1:0] w_ctl_masked;

    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wdata;
    t_entry           w_rdata;
    t_match           w_match;
    t_key             w_frame_key;

    // Entry storage: key plus command flag
    llcdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Shared key comparator
    llcdt_key_cmp u_cmp (
        .i_stored (w_rdata.key),
        .i_frame  (r_key),
        .o_match  (w_match)
    );

    assign w_in_xfer    = i_in_valid && o_in_ready;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_ctl_masked = i_llc_control & AC_MASK;
    assign w_ac         = (w_ctl_masked == AC_VALUE);
    assign w_last       = ((CNT_W'(r_idx) + CNT_ONE) == r_count);

    always_comb begin
        w_frame_key.dmac = i_dest_mac;
        w_frame_key.smac = i_source_mac;
        w_frame_key.dsap = i_dest_sap;
        w_frame_key.ssap = i_source_sap;
    end

    // Sequencer next state and table write
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        n_cmd   = r_cmd;
        n_full  = r_full;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = {w_rdata.key, ~w_rdata.flag};
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_idx  = '0;
                    n_cmd  = 1'b0;
                    n_full = 1'b0;
                    if (!w_ac) begin
                        n_state = S_OUT;
                    end else if (r_count == '0) begin
                        n_state = S_INS;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_match.fwd_hit || w_match.rev_hit) begin
                    w_we    = 1'b1;
                    n_cmd   = ~w_rdata.flag;
                    n_state = S_OUT;
                end else if (w_last) begin
                    n_state = S_INS;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_INS: begin
                if (r_count < CNT_FULL) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[IDX_W-1:0];
                    w_wdata = {r_key, 1'b1};
                    n_count = r_count + CNT_ONE;
                    n_cmd   = 1'b1;
                end else begin
                    n_full  = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_OUT && w_out_free) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers for the current frame
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cmd  <= n_cmd;
        r_full <= n_full;
        if (w_in_xfer) begin
            r_key   <= w_frame_key;
            r_is_ac <= w_ac;
            r_seq   <= i_llc_control[SEQ_POS];
            r_pf    <= i_llc_control[PF_POS];
            r_unnum <= (i_llc_control == UNNUM);
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_ac    <= r_is_ac;
            r_out_seq   <= r_seq;
            r_out_pf    <= r_pf;
            r_out_unnum <= r_unnum;
            r_out_cmd   <= r_cmd;
            r_out_full  <= r_full;
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_is_ack_connless = r_out_ac;
    assign o_ac_sequence     = r_out_seq;
    assign o_poll_final      = r_out_pf;
    assign o_is_unnumbered   = r_out_unnum;
    assign o_is_command      = r_out_cmd;
    assign o_table_full      = r_out_full;

endmodule

@@ hdl/llcdt_checker.sv @@
// Port-level checks for the LLC conversation direction tracker, with bind.
// Depends on llcdt_pkg and llc_conversation_direction_tracker_unit.
module llcdt_checker
    import llcdt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic [MAC_W-1:0] i_dest_mac,
    input logic [MAC_W-1:0] i_source_mac,
    input logic [SAP_W-1:0] i_dest_sap,
    input logic [SAP_W-1:0] i_source_sap,
    input logic [CTL_W-1:0] i_llc_control,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_is_ack_connless,
    input logic             o_ac_sequence,
    input logic             o_poll_final,
    input logic             o_is_unnumbered,
    input logic             o_is_command,
    input logic             o_table_full
);

    // A pending result is held until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // One frame at a time: ready drops after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // Table lookups only happen for AC frames
    a_non_ac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_ack_connless |-> !o_is_command && !o_table_full)
        else $error("non-AC frame touched the table");

    // A full table on a miss never reports command
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> !o_is_command)
        else $error("table full with command set");

    // An all-zero control byte is never AC
    a_unnum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_unnumbered |-> !o_is_ack_connless)
        else $error("unnumbered frame classified as AC");

endmodule

bind llc_conversation_direction_tracker_unit llcdt_checker u_llcdt_checker (.*);

@@ verif/llc_conversation_direction_tracker_unit_tb.sv @@
// Testbench for the LLC conversation direction tracker: random and directed frames,
// a predicted conversation table and field-by-field checks of every result.
// Depends on llcdt_pkg and llc_conversation_direction_tracker_unit.
module llc_conversation_direction_tracker_unit_tb;
    import llcdt_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HALF_PERIOD = 10;
    localparam int POOL_SIZE   = 20;
    localparam int RANDOM_FRAMES = 830;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 400;

    // One frame's addressing plus its control byte
    typedef struct packed {
        t_key             key;
        logic [CTL_W-1:0] ctl;
    } t_frame;

    // One classification result
    typedef struct packed {
        logic ack;
        logic seq;
        logic pf;
        logic unnum;
        logic cmd;
        logic full;
    } t_verdict;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [MAC_W-1:0] dest_mac  = '0;
    logic [MAC_W-1:0] src_mac   = '0;
    logic [SAP_W-1:0] dest_sap  = '0;
    logic [SAP_W-1:0] src_sap   = '0;
    logic [CTL_W-1:0] llc_ctl   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             is_ack_connless;
    logic             ac_sequence;
    logic             poll_final;
    logic             is_unnumbered;
    logic             is_command;
    logic             table_full;

    // Predicted conversation table
    t_key     conv_key  [DEPTH];
    logic     conv_live [DEPTH];
    logic     conv_cmd  [DEPTH];
    int       conv_used = 0;

    t_frame   frames_to_send[$];
    t_verdict expected_verdicts[$];
    t_key     key_pool[POOL_SIZE];

    logic     frame_taken  = 1'b0;
    logic     result_taken = 1'b0;
    logic     run_failed   = 1'b0;
    int       results_seen = 0;
    int       tx_gap = 0, tx_calm = 0;
    int       rx_gap = 0, rx_calm = 0, hold_left = 0;
    logic     hold_done = 1'b0;

    llc_conversation_direction_tracker_unit #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_dest_mac       (dest_mac),
        .i_source_mac     (src_mac),
        .i_dest_sap       (dest_sap),
        .i_source_sap     (src_sap),
        .i_llc_control    (llc_ctl),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_is_ack_connless(is_ack_connless),
        .o_ac_sequence    (ac_sequence),
        .o_poll_final     (poll_final),
        .o_is_unnumbered  (is_unnumbered),
        .o_is_command     (is_command),
        .o_table_full     (table_full)
    );

    // Clock
    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Same conversation seen from the other end
    function automatic t_key swap_ends(input t_key k);
        t_key r;
        r.dmac = k.smac;
        r.smac = k.dmac;
        r.dsap = k.ssap;
        r.ssap = k.dsap;
        return r;
    endfunction

    // Classify the control byte and update the predicted table
    function automatic t_verdict track_frame(input t_frame f);
        t_verdict v;
        t_key     rev;
        logic     hit;
        int       i;
        v       = '0;
        v.ack   = (f.ctl & AC_MASK) == AC_VALUE;
        v.seq   = f.ctl[SEQ_POS];
        v.pf    = f.ctl[PF_POS];
        v.unnum = f.ctl == UNNUM;
        rev     = swap_ends(f.key);
        hit     = 1'b0;
        if (v.ack) begin
            // lowest matching entry wins
            for (i = 0; i < DEPTH; i++) begin
                if (!hit && conv_live[i] && (conv_key[i] == f.key || conv_key[i] == rev)) begin
                    conv_cmd[i] = !conv_cmd[i];
                    v.cmd       = conv_cmd[i];
                    hit         = 1'b1;
                end
            end
            if (!hit) begin
                if (conv_used < DEPTH) begin
                    conv_key[conv_used]  = f.key;
                    conv_live[conv_used] = 1'b1;
                    conv_cmd[conv_used]  = 1'b1;
                    conv_used++;
                    v.cmd = 1'b1;
                end else begin
                    v.full = 1'b1;
                end
            end
        end
        return v;
    endfunction

    // Idle length: mostly none or short, a few long, with idle-free stretches
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_key rand_key();
        t_key k;
        k.dmac = {16'($urandom), 32'($urandom)};
        k.smac = {16'($urandom), 32'($urandom)};
        k.dsap = 8'($urandom);
        k.ssap = 8'($urandom);
        return k;
    endfunction

    task automatic queue_frame(input t_key k, input logic [CTL_W-1:0] ctl);
        t_frame f;
        f.key = k;
        f.ctl = ctl;
        frames_to_send.insert(frames_to_send.size(), f);
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            run_failed = 1'b1;
        end
    endtask

    // Sender: offers frames from the queue, holds each until its transfer
    always @(negedge clk) begin : sender
        t_frame f;
        if (!rst_n || (in_valid && !frame_taken)) begin
            // keep current frame on the bus
        end else if (tx_gap > 0) begin
            in_valid <= 1'b0;
            tx_gap--;
        end else if (frames_to_send.size() != 0) begin
            f = frames_to_send.pop_front();
            dest_mac <= f.key.dmac;
            src_mac  <= f.key.smac;
            dest_sap <= f.key.dsap;
            src_sap  <= f.key.ssap;
            llc_ctl  <= f.ctl;
            in_valid <= 1'b1;
            tx_gap = idle_len(tx_calm);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the block
    always @(negedge clk) begin
        if (result_taken)
            rx_gap = idle_len(rx_calm);
        if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (rx_gap > 0) begin
            out_ready <= 1'b0;
            rx_gap--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: check results first, then predict the frame taken at this edge
    always @(posedge clk) begin : monitor
        t_verdict want;
        t_frame   f;
        if (rst_n) begin
            frame_taken  <= in_valid && in_ready;
            result_taken <= out_valid && out_ready;
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: result with nothing expected", $time);
                    run_failed = 1'b1;
                end else begin
                    want = expected_verdicts.pop_front();
                    check_field("is_ack_connless", want.ack, is_ack_connless);
                    check_field("ac_sequence", want.seq, ac_sequence);
                    check_field("poll_final", want.pf, poll_final);
                    check_field("is_unnumbered", want.unnum, is_unnumbered);
                    check_field("is_command", want.cmd, is_command);
                    check_field("table_full", want.full, table_full);
                end
            end
            if (in_valid && in_ready) begin
                f.key.dmac = dest_mac;
                f.key.smac = src_mac;
                f.key.dsap = dest_sap;
                f.key.ssap = src_sap;
                f.ctl      = llc_ctl;
                expected_verdicts.insert(expected_verdicts.size(), track_frame(f));
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        t_key             kmin, kones, ka, k;
        logic [KEY_W-1:0] kbits;
        logic [CTL_W-1:0] ctl;
        int               n, r;

        for (n = 0; n < DEPTH; n++) begin
            conv_live[n] = 1'b0;
            conv_cmd[n]  = 1'b0;
        end

        // Directed frames
        kmin  = {{MAC_W{1'b0}}, {MAC_W{1'b1}}, 8'h00, 8'hff};
        kones = {{MAC_W{1'b1}}, {MAC_W{1'b1}}, 8'hff, 8'hff};
        ka    = rand_key();
        queue_frame('0, UNNUM);                      // unnumbered, non-AC
        queue_frame(kones, 8'hff);                   // non-AC, all control bits set
        queue_frame(kmin, AC_VALUE);                 // AC0, new conversation
        queue_frame(kmin, AC_VALUE | 8'h80);         // AC1, same direction
        queue_frame(swap_ends(kmin), 8'hf7);         // reversed, poll set
        queue_frame(swap_ends(kmin), 8'h77);
        queue_frame(kmin, 8'h10);                    // non-AC leaves the table alone
        queue_frame(kmin, 8'h80);
        queue_frame(kmin, AC_VALUE);
        queue_frame(kones, AC_VALUE);                // key equal to its own reverse
        queue_frame(kones, AC_VALUE);
        queue_frame(ka, AC_VALUE);
        k = ka;
        k.dsap = k.dsap ^ 8'h01;                     // one SAP bit off: new entry
        queue_frame(k, AC_VALUE);
        k = ka;
        k.dmac = ka.smac;
        k.smac = ka.dmac;                            // MACs swapped, SAPs not: new entry
        queue_frame(k, 8'he7);
        queue_frame(ka, 8'h47);                      // near-AC control bytes
        queue_frame(ka, 8'h6f);
        queue_frame(ka, 8'h65);
        queue_frame(ka, 8'h27);
        queue_frame(swap_ends(ka), 8'hf7);

        // Conversation pool: a few close neighbors among mostly random keys
        for (n = 0; n < POOL_SIZE; n++)
            key_pool[n] = rand_key();
        key_pool[3]      = key_pool[2];
        key_pool[3].ssap = ~key_pool[2].ssap;
        key_pool[5].smac = key_pool[5].dmac;
        key_pool[5].ssap = key_pool[5].dsap;
        key_pool[7]      = key_pool[6];
        key_pool[7].dmac = key_pool[6].smac;
        key_pool[7].smac = key_pool[6].dmac;

        // Random frames: mostly AC traffic on known conversations
        for (n = 0; n < RANDOM_FRAMES; n++) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                ctl = AC_VALUE;
                ctl[SEQ_POS] = 1'($urandom_range(0, 1));
                ctl[PF_POS]  = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 99);
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (r < 70) begin
                    if ($urandom_range(0, 1))
                        k = swap_ends(k);
                end else if (r < 85) begin
                    kbits = k;
                    kbits[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
                    k = kbits;
                end else begin
                    k = rand_key();
                end
            end else begin
                ctl = ($urandom_range(0, 9) == 0) ? UNNUM : CTL_W'($urandom);
                k = ($urandom_range(0, 1)) ? rand_key() : key_pool[$urandom_range(0, 3)];
            end
            queue_frame(k, ctl);
        end

        // Reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain
        while (frames_to_send.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 10) @(posedge clk);

        if (!run_failed && expected_verdicts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #(2 * HALF_PERIOD * 1000000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hdl/llcdt_pkg.sv
hdl/llcdt_ram.sv
hdl/llcdt_key_cmp.sv
hdl/llc_conversation_direction_tracker_unit.sv
hdl/llcdt_checker.sv
verif/llc_conversation_direction_tracker_unit_tb.sv
